// ----- rtl/mnp_pkg.sv -----
// Shared types and constants of the multibase number parser.
`default_nettype none

package mnp_pkg;

   // Number base selected by the prefix
   typedef enum logic [1:0] {
      RX_DEC = 2'd0,
      RX_HEX = 2'd1,
      RX_BIN = 2'd2
   } radix_type;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_INVALID  = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_F = 8'h66;
   localparam logic [7:0] CH_LOWER_B = 8'h62;
   localparam logic [7:0] CH_LOWER_X = 8'h78;

   localparam int VALUE_W = 32;
   localparam logic [35:0] TOP_VALUE = 36'h0_FFFF_FFFF;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [1:0]         status;
   } result_type;

endpackage

`default_nettype wire

// ----- rtl/mnp_digit.sv -----
// Digit decoder: maps one ASCII character to its value in the current base.
`default_nettype none

module mnp_digit (
   input  wire logic [7:0]        ch,
   input  wire mnp_pkg::radix_type radix,
   output logic                   ok,
   output logic [3:0]             digit
);
   import mnp_pkg::*;

   logic is_dec;
   logic is_upper;
   logic is_lower;

   assign is_dec   = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign is_upper = (ch >= CH_UPPER_A) && (ch <= CH_UPPER_F);
   assign is_lower = (ch >= CH_LOWER_A) && (ch <= CH_LOWER_F);

   always_comb begin
      ok    = 1'b0;
      digit = 4'd0;
      unique case (radix)
         RX_HEX: begin
            if (is_dec) begin
               ok    = 1'b1;
               digit = ch[3:0];
            end else if (is_upper || is_lower) begin
               ok    = 1'b1;
               digit = 4'd9 + {1'b0, ch[2:0]};
            end
         end
         RX_BIN: begin
            ok    = (ch == CH_ZERO) || (ch == CH_ZERO + 8'd1);
            digit = {3'b000, ch[0]};
         end
         default: begin
            ok    = is_dec;
            digit = ch[3:0];
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/mnp_core.sv -----
// Parse state and per-character step logic of the number parser.
`default_nettype none

module mnp_core #(
   parameter int MAX_LEN = 255
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic [7:0]        ch,
   input  wire logic              last,
   output mnp_pkg::result_type    result
);
   import mnp_pkg::*;

   localparam int CW = $clog2(MAX_LEN + 1);

   typedef enum logic [2:0] {
      PH_START  = 3'd0,
      PH_MINUS  = 3'd1,
      PH_ZERO   = 3'd2,
      PH_PREFIX = 3'd3,
      PH_DIGITS = 3'd4
   } phase_type;

   phase_type          phase_ff, phase_in;
   radix_type          radix_ff, radix_in;
   logic [VALUE_W-1:0] accum_ff, accum_in;
   logic               ovf_ff, ovf_in;
   logic               inv_ff, inv_in;
   logic [CW-1:0]      count_ff, count_in;

   logic               dig_ok;
   logic [3:0]         digit;
   logic [35:0]        scaled;
   logic [35:0]        sum;
   logic [VALUE_W-1:0] acc_step;
   logic               ovf_step;
   logic               inv_step;

   mnp_digit u_digit (
      .ch    (ch),
      .radix (radix_ff),
      .ok    (dig_ok),
      .digit (digit)
   );

   // Shift-add by the constant base, then range check.
   always_comb begin
      case (radix_ff)
         RX_HEX:  scaled = {accum_ff, 4'b0000};
         RX_BIN:  scaled = {3'b000, accum_ff, 1'b0};
         default: scaled = {1'b0, accum_ff, 3'b000} + {3'b000, accum_ff, 1'b0};
      endcase
      sum      = scaled + {32'd0, digit};
      acc_step = accum_ff;
      ovf_step = ovf_ff;
      inv_step = inv_ff;
      if (!dig_ok) begin
         inv_step = 1'b1;
      end else if (!ovf_ff) begin
         if (sum >= TOP_VALUE) begin
            ovf_step = 1'b1;
            acc_step = '1;
         end else begin
            acc_step = sum[VALUE_W-1:0];
         end
      end
   end

   always_comb begin
      phase_in = phase_ff;
      radix_in = radix_ff;
      accum_in = acc_step;
      ovf_in   = ovf_step;
      inv_in   = inv_step;
      count_in = (count_ff < CW'(MAX_LEN)) ? count_ff + CW'(1) : count_ff;
      unique case (phase_ff) inside
         PH_START, PH_MINUS: begin
            if ((phase_ff == PH_START) && (ch == CH_MINUS)) begin
               phase_in = PH_MINUS;
               accum_in = accum_ff;
               ovf_in   = ovf_ff;
               inv_in   = inv_ff;
            end else begin
               phase_in = (dig_ok && (digit == 4'd0)) ? PH_ZERO : PH_DIGITS;
            end
         end
         PH_ZERO: begin
            if ((ch == CH_LOWER_X) || (ch == CH_LOWER_B)) begin
               radix_in = (ch == CH_LOWER_X) ? RX_HEX : RX_BIN;
               accum_in = '0;
               ovf_in   = ovf_ff;
               inv_in   = inv_ff;
               phase_in = PH_PREFIX;
            end else begin
               phase_in = PH_DIGITS;
            end
         end
         default: phase_in = PH_DIGITS;
      endcase

      result.status = ST_OK;
      if (inv_in || (phase_in == PH_MINUS) ||
          ((phase_in == PH_PREFIX) && (count_in <= CW'(2)))) begin
         result.status = ST_INVALID;
      end else if (ovf_in) begin
         result.status = ST_OVERFLOW;
      end
      result.value = (result.status == ST_OK) ? accum_in : '0;
   end

   // The string ends on its last character; the state goes back to the start.
   always_ff @(posedge clock) begin
      if (reset || (step && last)) begin
         phase_ff <= PH_START;
         radix_ff <= RX_DEC;
         accum_ff <= '0;
         ovf_ff   <= 1'b0;
         inv_ff   <= 1'b0;
         count_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         radix_ff <= radix_in;
         accum_ff <= accum_in;
         ovf_ff   <= ovf_in;
         inv_ff   <= inv_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/multibase_number_parser_unit.sv -----
// Top level of the multibase ASCII number parser.
`default_nettype none

// The parser reads an ASCII number string, one character per transfer on the
// req_ channel, with req_tlast high on the final character. For each string it
// returns exactly one transfer on the rsp_ channel: the unsigned 32-bit value
// and a status (ok, invalid or overflow); the value is zero unless the status
// is ok. A single leading minus is skipped, "0x" selects hexadecimal digits of
// either case and "0b" selects binary, but only when the whole string is longer
// than two characters; anything else is decimal. Any value of 0xFFFFFFFF or
// above is reported as overflow, and an invalid character or form wins over
// overflow. Each character waits in the input register and is then folded
// into the parse state (a constant-base shift-add and a compare), so the
// unit sustains one character per clock cycle when it is not stalled. The
// result is offered once the last character has passed the input register
// and the result has been loaded into the output register. The only stall
// arises when a finished result still waits in the output register and the
// next string's last character is ready to complete.
module multibase_number_parser_unit #(
   parameter int MAX_LEN = 255
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] ch
   input  wire logic        req_tlast,   // last character of the string
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata    // [31:0] value, [33:32] status, rest zero
);
   import mnp_pkg::*;

   logic        in_valid_ff;
   logic [7:0]  in_ch_ff;
   logic        in_last_ff;
   logic        out_valid_ff;
   result_type  out_ff;
   result_type  step_result;
   logic        advance;

   // A character moves into the parse state unless it would finish a string
   // while the previous result is still held and not being taken.
   assign advance    = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_ch_ff   <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   mnp_core #(
      .MAX_LEN (MAX_LEN)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .ch     (in_ch_ff),
      .last   (in_last_ff),
      .result (step_result)
   );

   // Output register: loaded when a string completes, cleared once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && in_last_ff) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_last_ff) begin
         out_ff <= step_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b000000, out_ff.status, out_ff.value};

endmodule

`default_nettype wire
